/* rtl/fkg_pkg.sv */
package fkg_pkg;

  localparam int unsigned VAL_W = 16;
  localparam int unsigned WGT_W = 16;
  localparam int unsigned CAP_W = 24;
  localparam int unsigned TOT_W = 31;
  localparam int unsigned WHOLE_W = 7;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_WAIT,
    ST_SORT_CMP,
    ST_SORT_SWAP,
    ST_WALK_RD,
    ST_WALK_WAIT,
    ST_WALK_EVAL,
    ST_DIV,
    ST_OUT
  } fkg_state_t;

  typedef struct packed {
    logic [TOT_W-1:0]   total_value_q8;
    logic [WHOLE_W-1:0] whole_items_taken;
    logic               item_overflow;
  } fkg_result_t;

  typedef struct packed {
    logic [VAL_W-1:0] item_value;
    logic [WGT_W-1:0] item_weight;
    logic             last_item;
  } fkg_item_t;

endpackage

/* rtl/fkg_if.sv */
interface fkg_item_if;
  logic                valid;
  logic                ready;
  fkg_pkg::fkg_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fkg_result_if;
  logic                 valid;
  logic                 ready;
  fkg_pkg::fkg_result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/fkg_div.sv */
// Restoring divider, one quotient bit per cycle.
module fkg_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  assign shifted = {rem[DEN_W-1:0], q[NUM_W-1]};
  assign diff    = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      d   <= den;
    end else if (busy) begin
      if (!diff[DEN_W]) begin
        rem <= diff;
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quot = q;

endmodule

/* rtl/fractional_knapsack_greedy.sv */
// Greedy fractional knapsack. Items stream in one beat each, with the input
// ready throughout loading; the beat with last_item set starts the solve and
// the input holds ready low until the single result beat is taken. The solve
// is an exchange sort over the stored items, each pair read, waited on and
// compared through a shared 16x16 cross-product compare on a single-port
// memory, with each outer entry fetched once per pass and a swap writing both
// slots, then a walk that reads and weighs each sorted item and one restoring
// divide for the partial item.
// Items past MAX_ITEMS are dropped and reported through item_overflow.
module fractional_knapsack_greedy #(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [fkg_pkg::CAP_W-1:0] cfg_wdata,
  fkg_item_if.sink                  item,
  fkg_result_if.source              result
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned PRD_W = fkg_pkg::VAL_W + fkg_pkg::CAP_W;
  localparam int unsigned NUM_W = PRD_W + FRAC_BITS;
  localparam int unsigned ACC_W = fkg_pkg::TOT_W + 1;
  localparam int unsigned ENT_W = fkg_pkg::VAL_W + fkg_pkg::WGT_W;
  localparam logic [ACC_W-1:0] TOT_MAX = {1'b0, {fkg_pkg::TOT_W{1'b1}}};

  fkg_pkg::fkg_state_t state, state_next;

  logic [fkg_pkg::CAP_W-1:0] capacity;
  logic [ENT_W-1:0]          mem [MAX_ITEMS];
  logic [ENT_W-1:0]          rd_data;
  logic [ENT_W-1:0]          ent_a;
  logic [ENT_W-1:0]          ent_b;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_addr;
  logic [ENT_W-1:0]          mem_wdata;

  logic [CNT_W-1:0]          item_count;
  logic                      overflow_seen;
  logic [IDX_W-1:0]          idx_i;
  logic [IDX_W-1:0]          idx_j;
  logic                      rd_phase;
  logic                      load_a;
  logic                      swap_phase;
  logic                      cmp_lt;
  logic [31:0]               lhs;
  logic [31:0]               rhs;
  logic [fkg_pkg::CAP_W-1:0] remaining;
  logic [ACC_W-1:0]          total;
  logic [CNT_W-1:0]          whole;
  logic [PRD_W-1:0]          frac_prod;
  logic                      div_start;
  logic                      div_done;
  logic [NUM_W-1:0]          div_quot;
  logic [ACC_W-1:0]          add_val;
  logic [ACC_W:0]            sum;
  logic                      in_beat;
  logic                      cnt_full;
  logic [CNT_W-1:0]          j_next;
  logic                      res_valid;

  assign in_beat  = item.valid && item.ready;
  assign cnt_full = (item_count == CNT_W'(MAX_ITEMS));
  assign j_next   = CNT_W'(idx_j) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) capacity <= '0;
    else if (cfg_we) capacity <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[mem_addr];
  end

  // Shared compare unit: ratio(a) < ratio(b)  <=>  va*wb < vb*wa.
  always_ff @(posedge clk) begin
    lhs <= ent_a[ENT_W-1 -: fkg_pkg::VAL_W] * rd_data[fkg_pkg::WGT_W-1:0];
    rhs <= rd_data[ENT_W-1 -: fkg_pkg::VAL_W] * ent_a[fkg_pkg::WGT_W-1:0];
  end
  assign cmp_lt = lhs < rhs;

  assign frac_prod = rd_data[ENT_W-1 -: fkg_pkg::VAL_W] * remaining;

  always_comb begin
    state_next = state;
    unique case (state)
      fkg_pkg::ST_LOAD:
        if (in_beat && item.payload.last_item) begin
          if (item_count == '0 && cnt_full) state_next = fkg_pkg::ST_WALK_RD;
          else state_next = fkg_pkg::ST_SORT_RD;
        end
      fkg_pkg::ST_SORT_RD:
        if (CNT_W'(idx_i) + 1'b1 >= item_count) state_next = fkg_pkg::ST_WALK_RD;
        else if (rd_phase) state_next = fkg_pkg::ST_SORT_WAIT;
      fkg_pkg::ST_SORT_WAIT: state_next = fkg_pkg::ST_SORT_CMP;
      fkg_pkg::ST_SORT_CMP:
        if (cmp_lt) state_next = fkg_pkg::ST_SORT_SWAP;
        else state_next = fkg_pkg::ST_SORT_RD;
      fkg_pkg::ST_SORT_SWAP:
        if (swap_phase) state_next = fkg_pkg::ST_SORT_RD;
      fkg_pkg::ST_WALK_RD:
        if (CNT_W'(idx_i) >= item_count) state_next = fkg_pkg::ST_OUT;
        else state_next = fkg_pkg::ST_WALK_WAIT;
      fkg_pkg::ST_WALK_WAIT: state_next = fkg_pkg::ST_WALK_EVAL;
      fkg_pkg::ST_WALK_EVAL:
        if (rd_data[fkg_pkg::WGT_W-1:0] <= remaining) begin
          if (CNT_W'(idx_i) + 1'b1 >= item_count) state_next = fkg_pkg::ST_OUT;
          else state_next = fkg_pkg::ST_WALK_RD;
        end else begin
          state_next = fkg_pkg::ST_DIV;
        end
      fkg_pkg::ST_DIV:
        if (div_done) state_next = fkg_pkg::ST_OUT;
      fkg_pkg::ST_OUT:
        if (result.ready) state_next = fkg_pkg::ST_LOAD;
      default: state_next = fkg_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx_i;
    mem_wdata = ent_a;
    item.ready = 1'b0;
    res_valid = 1'b0;
    div_start = 1'b0;
    add_val   = '0;
    unique case (state)
      fkg_pkg::ST_LOAD: begin
        item.ready = 1'b1;
        mem_addr   = item_count[IDX_W-1:0];
        mem_wdata  = {item.payload.item_value, item.payload.item_weight};
        mem_we     = item.valid && !cnt_full;
      end
      fkg_pkg::ST_SORT_RD: mem_addr = rd_phase ? idx_j : idx_i;
      fkg_pkg::ST_SORT_WAIT: mem_addr = idx_j;
      fkg_pkg::ST_SORT_CMP: mem_addr = idx_j;
      fkg_pkg::ST_SORT_SWAP: begin
        mem_we    = 1'b1;
        mem_addr  = swap_phase ? idx_j : idx_i;
        mem_wdata = swap_phase ? ent_a : ent_b;
      end
      fkg_pkg::ST_WALK_EVAL: begin
        add_val   = ACC_W'(rd_data[ENT_W-1 -: fkg_pkg::VAL_W]) << FRAC_BITS;
        div_start = rd_data[fkg_pkg::WGT_W-1:0] > remaining;
      end
      fkg_pkg::ST_DIV:
        if (div_done) begin
          if (div_quot > NUM_W'(TOT_MAX)) add_val = TOT_MAX;
          else add_val = ACC_W'(div_quot);
        end
      fkg_pkg::ST_OUT: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign sum = {1'b0, total} + {1'b0, add_val};

  fkg_div #(
    .NUM_W (NUM_W),
    .DEN_W (fkg_pkg::WGT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (NUM_W'(frac_prod) << FRAC_BITS),
    .den   (rd_data[fkg_pkg::WGT_W-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fkg_pkg::ST_LOAD;
      item_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fkg_pkg::ST_LOAD && in_beat) begin
        if (cnt_full) overflow_seen <= 1'b1;
        else item_count <= item_count + 1'b1;
      end
      if (state == fkg_pkg::ST_OUT && result.ready) begin
        item_count    <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      fkg_pkg::ST_LOAD: begin
        idx_i      <= '0;
        idx_j      <= IDX_W'(1);
        rd_phase   <= 1'b0;
        load_a     <= 1'b0;
        swap_phase <= 1'b0;
        total      <= '0;
        whole      <= '0;
        remaining  <= capacity;
      end
      fkg_pkg::ST_SORT_RD: begin
        if (CNT_W'(idx_i) + 1'b1 >= item_count) begin
          idx_i <= '0;
        end else if (!rd_phase) begin
          rd_phase <= 1'b1;
          load_a   <= 1'b1;
        end else begin
          // fetch slot i only once per outer pass
          if (load_a) ent_a <= rd_data;
          load_a <= 1'b0;
        end
      end
      fkg_pkg::ST_SORT_CMP: begin
        ent_b      <= rd_data;
        swap_phase <= 1'b0;
        if (!cmp_lt) begin
          // advance to the next pair
          if (j_next >= item_count) begin
            idx_i    <= idx_i + 1'b1;
            idx_j    <= idx_i + IDX_W'(2);
            rd_phase <= 1'b0;
          end else begin
            idx_j <= IDX_W'(j_next);
          end
        end
      end
      fkg_pkg::ST_SORT_SWAP: begin
        swap_phase <= 1'b1;
        if (swap_phase) begin
          // slot i now holds the old j entry
          ent_a <= ent_b;
          if (j_next >= item_count) begin
            idx_i    <= idx_i + 1'b1;
            idx_j    <= idx_i + IDX_W'(2);
            rd_phase <= 1'b0;
          end else begin
            idx_j <= IDX_W'(j_next);
          end
        end
      end
      fkg_pkg::ST_WALK_EVAL: begin
        ent_b <= rd_data;
        if (rd_data[fkg_pkg::WGT_W-1:0] <= remaining) begin
          remaining <= remaining - fkg_pkg::CAP_W'(rd_data[fkg_pkg::WGT_W-1:0]);
          total     <= sum[ACC_W] || sum[ACC_W-1:0] > TOT_MAX ? TOT_MAX : sum[ACC_W-1:0];
          whole     <= whole + 1'b1;
          idx_i     <= idx_i + 1'b1;
        end
      end
      fkg_pkg::ST_DIV:
        if (div_done) begin
          total <= sum[ACC_W] || sum[ACC_W-1:0] > TOT_MAX ? TOT_MAX : sum[ACC_W-1:0];
        end
      default: ;
    endcase
  end

  assign result.valid                     = res_valid;
  assign result.payload.total_value_q8    = total[fkg_pkg::TOT_W-1:0];
  assign result.payload.whole_items_taken = (32'(whole) > 32'd127) ?
                                            {fkg_pkg::WHOLE_W{1'b1}} :
                                            fkg_pkg::WHOLE_W'(whole);
  assign result.payload.item_overflow     = overflow_seen;

  a_ready_only_load: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> state == fkg_pkg::ST_LOAD)
    else $error("input ready outside load");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CNT_W'(MAX_ITEMS))
    else $error("item count past store depth");
  a_clear_after_out: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready |=> item_count == '0 && !overflow_seen)
    else $error("set state not cleared after result");
  a_whole_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> whole <= item_count)
    else $error("whole count exceeds items");

endmodule

/* dv/fkg_tb_if.sv */
interface fkg_cfg_port (input logic clk);
  logic                      we;
  logic [fkg_pkg::CAP_W-1:0] wdata;
endinterface

/* dv/fractional_knapsack_greedy_test.sv */
module fractional_knapsack_greedy_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_N = 64;
  localparam int unsigned FRAC = 8;
  localparam longint unsigned TOTAL_CAP = 64'h7FFF_FFFF;
  localparam int unsigned STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fkg_cfg_port  cfg (.clk(clk));
  fkg_item_if   item ();
  fkg_result_if result ();

  fractional_knapsack_greedy dut (
    .clk(clk), .rst(rst), .cfg_we(cfg.we), .cfg_wdata(cfg.wdata),
    .item(item.sink), .result(result.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [fkg_pkg::CAP_W-1:0] knap_capacity;
  logic [fkg_pkg::VAL_W-1:0] set_values [MAX_N];
  logic [fkg_pkg::WGT_W-1:0] set_weights [MAX_N];
  int unsigned               set_count;
  bit                        set_overflow;
  fkg_pkg::fkg_result_t      pending_totals [$];
  int unsigned               fails = 0;
  int unsigned               quiet_cycles = 0;

  function automatic fkg_pkg::fkg_result_t solve_set();
    fkg_pkg::fkg_result_t r;
    logic [fkg_pkg::VAL_W-1:0] v [MAX_N];
    logic [fkg_pkg::WGT_W-1:0] w [MAX_N];
    logic [fkg_pkg::VAL_W-1:0] tv;
    logic [fkg_pkg::WGT_W-1:0] tw;
    longint unsigned total, remaining, part;
    int unsigned whole;
    for (int k = 0; k < MAX_N; k++) begin
      v[k] = set_values[k];
      w[k] = set_weights[k];
    end
    for (int i = 0; i + 1 < set_count; i++)
      for (int j = i + 1; j < set_count; j++)
        if (64'(v[i]) * w[j] < 64'(v[j]) * w[i]) begin
          tv = v[i]; tw = w[i];
          v[i] = v[j]; w[i] = w[j];
          v[j] = tv; w[j] = tw;
        end
    total = 0;
    whole = 0;
    remaining = knap_capacity;
    for (int i = 0; i < set_count; i++) begin
      if (w[i] <= remaining) begin
        total += 64'(v[i]) << FRAC;
        if (total > TOTAL_CAP) total = TOTAL_CAP;
        remaining -= w[i];
        whole++;
      end else begin
        part = ((64'(v[i]) * remaining) << FRAC) / w[i];
        total += part;
        if (total > TOTAL_CAP) total = TOTAL_CAP;
        break;
      end
    end
    r.total_value_q8 = total[fkg_pkg::TOT_W-1:0];
    r.whole_items_taken = (whole > 127) ? 7'd127 : whole[fkg_pkg::WHOLE_W-1:0];
    r.item_overflow = set_overflow;
    return r;
  endfunction

  task automatic send_item(input logic [fkg_pkg::VAL_W-1:0] val,
                           input logic [fkg_pkg::WGT_W-1:0] wgt, input bit last);
    int unsigned gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.payload <= '{item_value: val, item_weight: wgt, last_item: last};
    do @(posedge clk); while (item.ready !== 1'b1);
    if (set_count < MAX_N) begin
      set_values[set_count] = val;
      set_weights[set_count] = wgt;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (last) begin
      pending_totals.push_back(solve_set());
      set_count = 0;
      set_overflow = 1'b0;
    end
  endtask

  task automatic write_capacity(input logic [fkg_pkg::CAP_W-1:0] cap);
    item.valid <= 1'b0;
    wait (pending_totals.size() == 0);
    repeat (10) @(posedge clk);
    cfg.we <= 1'b1;
    cfg.wdata <= cap;
    @(posedge clk);
    cfg.we <= 1'b0;
    knap_capacity = cap;
  endtask

  task automatic send_set(input int unsigned n, input int unsigned max_w);
    for (int k = 0; k < n; k++)
      send_item(fkg_pkg::VAL_W'($urandom), fkg_pkg::WGT_W'($urandom_range(1, max_w)),
                k == n - 1);
  endtask

  task automatic test_extremes();
    write_capacity('0);
    send_item(16'hFFFF, 16'hFFFF, 1'b1);
    write_capacity({fkg_pkg::CAP_W{1'b1}});
    send_item(16'hFFFF, 16'hFFFF, 1'b0);
    send_item(16'h0000, 16'h0001, 1'b0);
    send_item(16'hFFFF, 16'h0001, 1'b1);
    write_capacity(24'd100);
    send_item(16'd60, 16'd10, 1'b0);
    send_item(16'd100, 16'd20, 1'b0);
    send_item(16'd120, 16'd30, 1'b0);
    send_item(16'd7, 16'd7, 1'b0);
    send_item(16'd1, 16'd3, 1'b1);
  endtask

  task automatic test_overflow();
    // drop beats past the store, then a dropped final beat
    write_capacity(24'd5000);
    for (int k = 0; k < MAX_N + 3; k++)
      send_item(fkg_pkg::VAL_W'($urandom), fkg_pkg::WGT_W'($urandom_range(1, 200)),
                k == MAX_N + 2);
  endtask

  task automatic test_saturation();
    // many heavy values fit whole, driving the total high but below its limit
    write_capacity({fkg_pkg::CAP_W{1'b1}});
    for (int k = 0; k < MAX_N; k++)
      send_item(16'hFFFF, 16'h0001, k == MAX_N - 1);
  endtask

  task automatic test_random();
    logic [fkg_pkg::CAP_W-1:0] caps [4] = '{24'd1, 24'd300, 24'd40000,
                                            {fkg_pkg::CAP_W{1'b1}}};
    int unsigned sent;
    sent = 0;
    while (sent < 880) begin
      write_capacity(($urandom_range(0, 3) == 0) ? fkg_pkg::CAP_W'($urandom) :
                     caps[$urandom_range(0, 3)]);
      repeat (4) begin
        int unsigned n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, MAX_N + 4) :
                                          $urandom_range(1, 12);
        send_set(n, ($urandom_range(0, 1) == 0) ? 100 : 65535);
        sent += n;
      end
    end
  endtask

  // result checker with random back-pressure
  initial begin
    int unsigned gap;
    fkg_pkg::fkg_result_t got, want;
    result.ready = 1'b0;
    forever begin
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        result.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (result.valid !== 1'b1);
      got = result.payload;
      if (pending_totals.size() == 0) begin
        $display("%0t: unexpected result exp none act %p", $time, got);
        fails++;
      end else begin
        want = pending_totals.pop_front();
        if (got.total_value_q8 !== want.total_value_q8) begin
          $display("%0t: total exp %0d act %0d", $time, want.total_value_q8,
                   got.total_value_q8);
          fails++;
        end
        if (got.whole_items_taken !== want.whole_items_taken) begin
          $display("%0t: whole exp %0d act %0d", $time, want.whole_items_taken,
                   got.whole_items_taken);
          fails++;
        end
        if (got.item_overflow !== want.item_overflow) begin
          $display("%0t: overflow exp %0d act %0d", $time, want.item_overflow,
                   got.item_overflow);
          fails++;
        end
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((item.valid && item.ready) || (result.valid && result.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("fractional_knapsack_greedy: mismatch");
      $finish;
    end
  end

  initial begin
    item.valid = 1'b0;
    item.payload = '0;
    cfg.we = 1'b0;
    cfg.wdata = '0;
    set_count = 0;
    set_overflow = 1'b0;
    knap_capacity = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_overflow();
    test_saturation();
    test_random();
    item.valid <= 1'b0;
    wait (pending_totals.size() == 0);
    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("fractional_knapsack_greedy: match");
    else
      $display("fractional_knapsack_greedy: mismatch");
    $finish;
  end
endmodule

/* files.f */
rtl/fkg_pkg.sv
rtl/fkg_if.sv
rtl/fkg_div.sv
rtl/fractional_knapsack_greedy.sv
dv/fkg_tb_if.sv
dv/fractional_knapsack_greedy_test.sv
